// ===== rtl/core/pgpc_pkg.sv =====
// Package for the polygon gate point counter: sizes, item codes and shared types.
// No dependencies; every other file in rtl/core refers to it by scoped names.
`default_nettype none

package pgpc_pkg;

  // table capacity and coordinate format
  localparam int MAX_VERTICES = 16;
  localparam int COORD_BITS   = 32;
  localparam int MIN_USABLE   = 3;

  // derived widths
  localparam int IDX_W  = $clog2(MAX_VERTICES);
  localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * DIFF_W;

  // fixed field widths of the channels
  localparam int KIND_W  = 2;
  localparam int TOTAL_W = 32;
  localparam int HELD_W  = 5;

  // item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_TEST   = 2'd2
  } pgpc_kind_t;

  // one stored vertex
  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } pgpc_vertex_t;

  // edge walk request, aligned with the table read issue
  typedef struct packed {
    logic rd_en;
    logic first;
  } pgpc_walk_t;

  // edge unit status back to the sequencer
  typedef struct packed {
    logic busy;
    logic odd;
  } pgpc_edge_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/pgpc_if.sv =====
// Channel interfaces of the polygon gate point counter: item input and result output.
// Depends on pgpc_pkg for the field widths.
`default_nettype none

interface pgpc_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [pgpc_pkg::KIND_W-1:0]           kind;
  logic signed [pgpc_pkg::COORD_BITS-1:0] x_value;
  logic signed [pgpc_pkg::COORD_BITS-1:0] y_value;

  modport source (output valid, kind, x_value, y_value, input ready);
  modport sink   (input valid, kind, x_value, y_value, output ready);
endinterface

interface pgpc_out_if;
  logic                          valid;
  logic                          ready;
  logic                          inside_res;
  logic                          gate_usable;
  logic                          table_full;
  logic [pgpc_pkg::TOTAL_W-1:0]  kept_total;
  logic [pgpc_pkg::TOTAL_W-1:0]  tested_total;
  logic [pgpc_pkg::HELD_W-1:0]   vertices_held;

  modport source (output valid, inside_res, gate_usable, table_full, kept_total,
                  tested_total, vertices_held, input ready);
  modport sink   (input valid, inside_res, gate_usable, table_full, kept_total,
                  tested_total, vertices_held, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/polygon_gate_point_counter.sv =====
// Polygon gate point counter top level: sequencer, vertex table and edge pipeline.
// Depends on pgpc_pkg, pgpc_if, pgpc_vertex_ram, pgpc_edge_unit and pgpc_ctrl.
//
// Each input transaction clears the gate, appends one vertex or tests one point,
// and produces exactly one result transaction. Clear, append, unknown kinds and
// tests against an unusable gate go straight to loading their result. A test
// against a gate of n usable vertices reads the vertex table once per vertex plus
// once for the closing edge (one read per cycle on the single table read port),
// then drains a three-stage crossing pipeline before its result is loaded. Only
// one transaction is in work at a time; a finished result sits in the output
// register while the next transaction is taken in, and a new result waits for the
// sink to take the previous one. Vertex entries are undefined until appended and
// need no clearing after reset.
`default_nettype none

module polygon_gate_point_counter (
  input  wire logic  clk,
  input  wire logic  rst_n,
  pgpc_in_if.sink    in_ch,
  pgpc_out_if.source out_ch
);

  logic                            wr_en;
  logic [pgpc_pkg::IDX_W-1:0]      wr_addr;
  logic [pgpc_pkg::IDX_W-1:0]      rd_addr;
  pgpc_pkg::pgpc_vertex_t          wr_data;
  pgpc_pkg::pgpc_vertex_t          rd_data;
  pgpc_pkg::pgpc_walk_t            walk;
  pgpc_pkg::pgpc_edge_stat_t       stat;
  logic signed [pgpc_pkg::COORD_BITS-1:0] px, py;

  // sequencer and result register
  pgpc_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .walk    (walk),
    .px      (px),
    .py      (py),
    .stat    (stat)
  );

  // vertex table
  pgpc_vertex_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (walk.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // crossing pipeline
  pgpc_edge_unit u_edge (
    .clk     (clk),
    .rst_n   (rst_n),
    .walk    (walk),
    .rd_data (rd_data),
    .px      (px),
    .py      (py),
    .stat    (stat)
  );

endmodule

`default_nettype wire

// ===== rtl/core/pgpc_vertex_ram.sv =====
// Vertex table: one write port, one read port with registered read data.
// Depends on pgpc_pkg for the depth and the vertex type.
`default_nettype none

module pgpc_vertex_ram (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [pgpc_pkg::IDX_W-1:0] wr_addr,
  input  wire pgpc_pkg::pgpc_vertex_t     wr_data,
  input  wire logic                       rd_en,
  input  wire logic [pgpc_pkg::IDX_W-1:0] rd_addr,
  output pgpc_pkg::pgpc_vertex_t          rd_data
);

  pgpc_pkg::pgpc_vertex_t mem [pgpc_pkg::MAX_VERTICES];
  pgpc_pkg::pgpc_vertex_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== rtl/core/pgpc_edge_unit.sv =====
// Edge crossing pipeline: pairs consecutive vertices, cross-multiplies, toggles parity.
// Depends on pgpc_pkg; fed from the vertex table read port.
`default_nettype none

module pgpc_edge_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire pgpc_pkg::pgpc_walk_t                walk,
  input  wire pgpc_pkg::pgpc_vertex_t              rd_data,
  input  wire logic signed [pgpc_pkg::COORD_BITS-1:0] px,
  input  wire logic signed [pgpc_pkg::COORD_BITS-1:0] py,
  output pgpc_pkg::pgpc_edge_stat_t                stat
);

  localparam int DW  = pgpc_pkg::DIFF_W;
  localparam int PW  = pgpc_pkg::PROD_W;
  localparam int MSB = pgpc_pkg::COORD_BITS - 1;

  // read alignment
  logic rd_v_r, first_r;
  // previous vertex of the walk (the j end of the edge)
  pgpc_pkg::pgpc_vertex_t prev_r;
  // stage a: differences
  logic                 a_v_r, a_str_r, a_dpos_r;
  logic signed [DW-1:0] a_dxp_r, a_d_r, a_dxj_r, a_dpy_r;
  // stage b: products
  logic                 b_v_r, b_str_r, b_dpos_r;
  logic signed [PW-1:0] b_lp_r, b_rp_r;
  // parity accumulator
  logic acc_r, acc_nxt;
  logic crosses;

  // read data valid flags follow the issue in the next cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r  <= 1'b0;
      first_r <= 1'b0;
    end else begin
      rd_v_r  <= walk.rd_en;
      first_r <= walk.first;
    end
  end

  // hold the previous vertex
  always_ff @(posedge clk) begin
    if (rd_v_r) begin
      prev_r <= rd_data;
    end
  end

  // stage a: straddle test and the four differences
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else begin
      a_v_r <= rd_v_r && !first_r;
    end
  end

  always_ff @(posedge clk) begin
    a_str_r  <= (rd_data.y > py) != (prev_r.y > py);
    a_dpos_r <= prev_r.y > rd_data.y;
    a_dxp_r  <= {px[MSB], px} - {rd_data.x[MSB], rd_data.x};
    a_d_r    <= {prev_r.y[MSB], prev_r.y} - {rd_data.y[MSB], rd_data.y};
    a_dxj_r  <= {prev_r.x[MSB], prev_r.x} - {rd_data.x[MSB], rd_data.x};
    a_dpy_r  <= {py[MSB], py} - {rd_data.y[MSB], rd_data.y};
  end

  // stage b: cross products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    b_str_r  <= a_str_r;
    b_dpos_r <= a_dpos_r;
    b_lp_r   <= a_dxp_r * a_d_r;
    b_rp_r   <= a_dxj_r * a_dpy_r;
  end

  // stage c: sign-corrected compare and parity toggle
  assign crosses = b_dpos_r ? (b_lp_r < b_rp_r) : (b_rp_r < b_lp_r);

  always_comb begin
    acc_nxt = acc_r;
    if (walk.rd_en && walk.first) begin
      acc_nxt = 1'b0;
    end else if (b_v_r && b_str_r && crosses) begin
      acc_nxt = !acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= 1'b0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  assign stat.busy = rd_v_r || a_v_r || b_v_r;
  assign stat.odd  = acc_r;

endmodule

`default_nettype wire

// ===== rtl/core/pgpc_ctrl.sv =====
// Sequencer: takes transactions, keeps counts, walks the vertex table, holds the result.
// Depends on pgpc_pkg and the channel interfaces in pgpc_if.sv.
`default_nettype none

module pgpc_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  pgpc_in_if.sink                          in_ch,
  pgpc_out_if.source                       out_ch,
  output logic                             wr_en,
  output logic [pgpc_pkg::IDX_W-1:0]       wr_addr,
  output pgpc_pkg::pgpc_vertex_t           wr_data,
  output logic [pgpc_pkg::IDX_W-1:0]       rd_addr,
  output pgpc_pkg::pgpc_walk_t             walk,
  output logic signed [pgpc_pkg::COORD_BITS-1:0] px,
  output logic signed [pgpc_pkg::COORD_BITS-1:0] py,
  input  wire pgpc_pkg::pgpc_edge_stat_t   stat
);

  localparam int CW = pgpc_pkg::CNT_W;
  localparam int TW = pgpc_pkg::TOTAL_W;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_WALK  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     vcount_r, vcount_nxt;
  logic [CW-1:0]     rd_cnt_r, rd_cnt_nxt;
  logic [TW-1:0]     kept_r, kept_nxt;
  logic [TW-1:0]     tested_r, tested_nxt;
  logic              inside_r, inside_nxt;
  logic              full_r, full_nxt;
  logic signed [pgpc_pkg::COORD_BITS-1:0] px_r, py_r;
  logic              accept, out_free, load_out;
  logic [CW-1:0]     rd_idx;

  // output register
  logic              out_valid_r, out_inside_r, out_usable_r, out_full_r;
  logic [TW-1:0]     out_kept_r, out_tested_r;
  logic [pgpc_pkg::HELD_W-1:0] out_held_r;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign load_out    = (state_r == ST_EMIT) && out_free;

  // table write on append
  assign wr_en     = accept && (in_ch.kind == pgpc_pkg::KIND_APPEND) &&
                     (vcount_r < CW'(pgpc_pkg::MAX_VERTICES));
  assign wr_addr   = vcount_r[pgpc_pkg::IDX_W-1:0];
  assign wr_data.x = in_ch.x_value;
  assign wr_data.y = in_ch.y_value;

  // walk order: last vertex first, then vertex 0 upwards
  assign rd_idx     = (rd_cnt_r == '0) ? (vcount_r - CW'(1)) : (rd_cnt_r - CW'(1));
  assign rd_addr    = rd_idx[pgpc_pkg::IDX_W-1:0];
  assign walk.rd_en = (state_r == ST_WALK);
  assign walk.first = (state_r == ST_WALK) && (rd_cnt_r == '0);
  assign px         = px_r;
  assign py         = py_r;

  // sequencer and counters
  always_comb begin
    state_nxt  = state_r;
    vcount_nxt = vcount_r;
    rd_cnt_nxt = rd_cnt_r;
    kept_nxt   = kept_r;
    tested_nxt = tested_r;
    inside_nxt = inside_r;
    full_nxt   = full_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          inside_nxt = 1'b0;
          full_nxt   = 1'b0;
          state_nxt  = ST_EMIT;
          case (in_ch.kind)
            pgpc_pkg::KIND_CLEAR: begin
              vcount_nxt = '0;
              kept_nxt   = '0;
              tested_nxt = '0;
            end
            pgpc_pkg::KIND_APPEND: begin
              if (vcount_r < CW'(pgpc_pkg::MAX_VERTICES)) begin
                vcount_nxt = vcount_r + CW'(1);
              end else begin
                full_nxt = 1'b1;
              end
            end
            pgpc_pkg::KIND_TEST: begin
              if (tested_r != '1) begin
                tested_nxt = tested_r + TW'(1);
              end
              if (vcount_r >= CW'(pgpc_pkg::MIN_USABLE)) begin
                rd_cnt_nxt = '0;
                state_nxt  = ST_WALK;
              end
            end
            default: begin
              // unknown kind reports the current state only
            end
          endcase
        end
      end
      ST_WALK: begin
        rd_cnt_nxt = rd_cnt_r + CW'(1);
        if (rd_cnt_r == vcount_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!stat.busy) begin
          inside_nxt = stat.odd;
          if (stat.odd && (kept_r != '1)) begin
            kept_nxt = kept_r + TW'(1);
          end
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      vcount_r <= '0;
      rd_cnt_r <= '0;
      kept_r   <= '0;
      tested_r <= '0;
      inside_r <= 1'b0;
      full_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      vcount_r <= vcount_nxt;
      rd_cnt_r <= rd_cnt_nxt;
      kept_r   <= kept_nxt;
      tested_r <= tested_nxt;
      inside_r <= inside_nxt;
      full_r   <= full_nxt;
    end
  end

  // latch the test point
  always_ff @(posedge clk) begin
    if (accept) begin
      px_r <= in_ch.x_value;
      py_r <= in_ch.y_value;
    end
  end

  // result register, free to take the next result once the sink takes this one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_inside_r <= inside_r;
      out_usable_r <= vcount_r >= CW'(pgpc_pkg::MIN_USABLE);
      out_full_r   <= full_r;
      out_kept_r   <= kept_r;
      out_tested_r <= tested_r;
      out_held_r   <= pgpc_pkg::HELD_W'(vcount_r);
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.inside_res    = out_inside_r;
  assign out_ch.gate_usable   = out_usable_r;
  assign out_ch.table_full    = out_full_r;
  assign out_ch.kept_total    = out_kept_r;
  assign out_ch.tested_total  = out_tested_r;
  assign out_ch.vertices_held = out_held_r;

endmodule

`default_nettype wire

// ===== rtl/core/pgpc_checker.sv =====
// Port-level checks for the polygon gate point counter, bound to the top level.
// Depends on pgpc_pkg and polygon_gate_point_counter.
`default_nettype none

module pgpc_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic                          inside_res,
  input wire logic                          gate_usable,
  input wire logic                          table_full,
  input wire logic [pgpc_pkg::TOTAL_W-1:0]  kept_total,
  input wire logic [pgpc_pkg::TOTAL_W-1:0]  tested_total,
  input wire logic [pgpc_pkg::HELD_W-1:0]   vertices_held
);

  // a stalled result stays valid and holds its counts, inside flag and vertex count
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(kept_total) &&
      $stable(tested_total) && $stable(inside_res) && $stable(vertices_held))
    else $error("result changed while stalled");

  // one transaction in work at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a transaction is in work");

  // a point found inside needs a usable gate and nonzero counts
  a_inside_usable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && inside_res |-> gate_usable && kept_total != '0 && tested_total != '0)
    else $error("inside reported without usable gate or counts");

  // gate flag agrees with the vertex count, which stays within the table capacity
  a_usable_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> gate_usable == (vertices_held >= pgpc_pkg::HELD_W'(pgpc_pkg::MIN_USABLE))
      && vertices_held <= pgpc_pkg::HELD_W'(pgpc_pkg::MAX_VERTICES))
    else $error("gate flag or vertex count inconsistent");

  // a refused append only happens with a full table
  a_full_refused: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && table_full |->
      vertices_held == pgpc_pkg::HELD_W'(pgpc_pkg::MAX_VERTICES) && !inside_res)
    else $error("table full flagged with room left");

endmodule

bind polygon_gate_point_counter pgpc_checker u_pgpc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .inside_res    (out_ch.inside_res),
  .gate_usable   (out_ch.gate_usable),
  .table_full    (out_ch.table_full),
  .kept_total    (out_ch.kept_total),
  .tested_total  (out_ch.tested_total),
  .vertices_held (out_ch.vertices_held)
);

`default_nettype wire
